>>> rtl/bbcl_pkg.sv
// Package for the block buffer cache slot manager.
// Sizes, handshake payload structs, action/request/status codes and sequencer states.
// No dependencies.
package bbcl_pkg;

	// Slot array geometry
	localparam int SLOTS  = 32;
	localparam int IDX_W  = $clog2(SLOTS);
	localparam int CNT_W  = $clog2(SLOTS + 1);
	localparam int DEV_W  = 8;
	localparam int BLK_W  = 32;
	localparam int TAG_W  = DEV_W + BLK_W;
	localparam int HOLD_W = 8;
	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	// Action codes
	typedef logic [1:0] action_t;
	localparam action_t ACT_GET     = 2'd0;
	localparam action_t ACT_RELEASE = 2'd1;
	localparam action_t ACT_WRITE   = 2'd2;
	localparam action_t ACT_DONE    = 2'd3;

	// Disk request codes
	typedef logic [1:0] disk_req_t;
	localparam disk_req_t DREQ_NONE  = 2'd0;
	localparam disk_req_t DREQ_READ  = 2'd1;
	localparam disk_req_t DREQ_WRITE = 2'd2;

	// Status codes
	typedef logic [1:0] status_t;
	localparam status_t STAT_OK       = 2'd0;
	localparam status_t STAT_NO_BUF   = 2'd1;
	localparam status_t STAT_NOT_HELD = 2'd2;

	// Request payload
	typedef struct packed {
		action_t     action;
		logic [7:0]  device;
		logic [31:0] block_number;
		logic [4:0]  slot;
	} req_t;

	// Response payload
	typedef struct packed {
		logic [4:0] slot_out;
		logic       hit;
		disk_req_t  disk_request;
		status_t    status;
	} rsp_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_SCAN  = 3'b010,
		S_APPLY = 3'b100
	} state_t;

endpackage

>>> rtl/bbcl_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module bbcl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/block_buffer_cache_lru.sv
// Top level of the block buffer cache slot manager (LRU replacement).
// Depends on bbcl_pkg and bbcl_ram (tag store).
//
//   channel | valid     | ready     | payload
//   --------+-----------+-----------+--------------------------------
//   request | req_valid | req_ready | req (action, device, block, slot)
//   result  | rsp_valid | rsp_ready | rsp (slot_out, hit, disk_request, status)
//
// A get scans every slot, one tag store read per slot through the registered read
// port, into a single tag compare and rank compare unit; the apply step then issues
// the result and updates the target slot. Release, write and done go straight from
// the transfer to the apply step, which issues their result.
// req_ready is high only in idle, which the sequencer re-enters when the apply step
// issues a result, so no new request is taken while one is still in progress.
// The apply step stalls while a previous result is still waiting on rsp_ready.
// Reset: tags read as zero until a slot is retagged; slot i starts at rank SLOTS-1-i.
module block_buffer_cache_lru (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  bbcl_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output bbcl_pkg::rsp_t rsp
);
	import bbcl_pkg::*;

	state_t             state_q;
	req_t               cmd_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_found_q;
	logic               vic_found_q;
	logic [IDX_W-1:0]   hit_idx_q;
	logic [IDX_W-1:0]   vic_idx_q;
	logic [IDX_W-1:0]   hit_rank_q;
	logic [IDX_W-1:0]   vic_rank_q;
	rsp_t               rsp_q;
	logic               rsp_valid_q;

	// per-slot metadata
	logic [HOLD_W-1:0]  holder_q [SLOTS];
	logic [IDX_W-1:0]   rank_q   [SLOTS];
	logic [SLOTS-1:0]   valid_q;
	logic [SLOTS-1:0]   dirty_q;
	logic [SLOTS-1:0]   tagv_q;

	// tag store port
	logic               tag_we;
	logic [IDX_W-1:0]   tag_raddr;
	logic [TAG_W-1:0]   tag_rdata;
	logic [TAG_W-1:0]   req_tag;

	// metadata read port and scan compare
	logic               in_apply;
	logic               is_get;
	logic               slot_oor;
	logic [IDX_W-1:0]   tgt_idx;
	logic [IDX_W-1:0]   rd_idx;
	logic [HOLD_W-1:0]  rd_holder;
	logic [IDX_W-1:0]   rd_rank;
	logic               rd_valid;
	logic               rd_dirty;
	logic               rd_tagv;
	logic [TAG_W-1:0]   cur_tag;
	logic               hit_take;
	logic               vic_take;
	logic               scan_last;

	// apply step
	logic               can_fire;
	rsp_t               rsp_n;
	logic [HOLD_W-1:0]  hold_n;
	logic               valid_n;
	logic               dirty_n;
	logic               meta_we;
	logic               retag;
	logic               rank_sweep;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign in_apply = (state_q == S_APPLY);
	assign is_get   = (cmd_q.action == ACT_GET);
	assign slot_oor = (int'(cmd_q.slot) >= SLOTS);
	assign req_tag  = {cmd_q.device, cmd_q.block_number};

	// target slot of the apply step
	always_comb begin
		if (!is_get) begin
			tgt_idx = IDX_W'(cmd_q.slot);
		end else if (hit_found_q) begin
			tgt_idx = hit_idx_q;
		end else begin
			tgt_idx = vic_idx_q;
		end
	end

	// single metadata read address: scan entry or apply target
	assign rd_idx    = in_apply ? tgt_idx : idx_s1;
	assign rd_holder = holder_q[rd_idx];
	assign rd_rank   = rank_q[rd_idx];
	assign rd_valid  = valid_q[rd_idx];
	assign rd_dirty  = dirty_q[rd_idx];
	assign rd_tagv   = tagv_q[rd_idx];

	// tag store, read one slot per scan cycle
	assign tag_raddr = cnt_q[IDX_W-1:0];
	assign tag_we    = can_fire && retag;

	bbcl_ram #(
		.WIDTH (TAG_W),
		.DEPTH (SLOTS)
	) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (rd_idx),
		.wdata (req_tag),
		.raddr (tag_raddr),
		.rdata (tag_rdata)
	);

	// shared compare unit: most recent match and least recent free clean slot
	assign cur_tag   = rd_tagv ? tag_rdata : '0;
	assign hit_take  = vld_s1 && (cur_tag == req_tag) &&
		(!hit_found_q || (rd_rank < hit_rank_q));
	assign vic_take  = vld_s1 && (rd_holder == '0) && !rd_dirty &&
		(!vic_found_q || (rd_rank > vic_rank_q));
	assign scan_last = vld_s1 && (idx_s1 == IDX_W'(SLOTS - 1));

	// apply step: result and metadata update for the target slot
	assign can_fire = in_apply && (!rsp_valid_q || rsp_ready);

	always_comb begin
		rsp_n      = '0;
		hold_n     = rd_holder;
		valid_n    = rd_valid;
		dirty_n    = rd_dirty;
		meta_we    = 1'b0;
		retag      = 1'b0;
		rank_sweep = 1'b0;
		if (is_get) begin
			if (hit_found_q) begin
				hold_n            = (rd_holder == HOLD_MAX) ? rd_holder :
					rd_holder + HOLD_W'(1);
				meta_we           = 1'b1;
				rsp_n.slot_out    = 5'(hit_idx_q);
				rsp_n.hit         = 1'b1;
				rsp_n.disk_request = rd_valid ? DREQ_NONE : DREQ_READ;
			end else if (vic_found_q) begin
				hold_n            = HOLD_W'(1);
				valid_n           = 1'b0;
				dirty_n           = 1'b0;
				meta_we           = 1'b1;
				retag             = 1'b1;
				rsp_n.slot_out    = 5'(vic_idx_q);
				rsp_n.disk_request = DREQ_READ;
			end else begin
				rsp_n.status = STAT_NO_BUF;
			end
		end else begin
			rsp_n.slot_out = cmd_q.slot;
			if (slot_oor) begin
				rsp_n.status = STAT_NOT_HELD;
			end else if (cmd_q.action == ACT_DONE) begin
				valid_n = 1'b1;
				dirty_n = 1'b0;
				meta_we = 1'b1;
			end else if (rd_holder == '0) begin
				rsp_n.status = STAT_NOT_HELD;
			end else if (cmd_q.action == ACT_WRITE) begin
				dirty_n            = 1'b1;
				meta_we            = 1'b1;
				rsp_n.disk_request = DREQ_WRITE;
			end else begin
				hold_n     = rd_holder - HOLD_W'(1);
				meta_we    = 1'b1;
				rank_sweep = (rd_holder == HOLD_W'(1));
			end
		end
	end

	// metadata registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			tagv_q  <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				holder_q[i] <= '0;
				rank_q[i]   <= IDX_W'(SLOTS - 1 - i);
			end
		end else if (can_fire) begin
			if (meta_we) begin
				holder_q[rd_idx] <= hold_n;
				valid_q[rd_idx]  <= valid_n;
				dirty_q[rd_idx]  <= dirty_n;
			end
			if (retag) begin
				tagv_q[rd_idx] <= 1'b1;
			end
			// last holder left: slot becomes most recent, newer slots age by one
			if (rank_sweep) begin
				for (int i = 0; i < SLOTS; i++) begin
					if (rank_q[i] < rd_rank) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end
				rank_q[rd_idx] <= '0;
			end
		end
	end

	// sequencer and scan trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			vld_s1      <= 1'b0;
			hit_found_q <= 1'b0;
			vic_found_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cnt_q       <= '0;
						vld_s1      <= 1'b0;
						hit_found_q <= 1'b0;
						vic_found_q <= 1'b0;
						state_q     <= (req.action == ACT_GET) ? S_SCAN : S_APPLY;
					end
				end
				S_SCAN: begin
					if (cnt_q != CNT_W'(SLOTS)) begin
						cnt_q  <= cnt_q + CNT_W'(1);
						vld_s1 <= 1'b1;
					end else begin
						vld_s1 <= 1'b0;
					end
					if (hit_take) begin
						hit_found_q <= 1'b1;
					end
					if (vic_take) begin
						vic_found_q <= 1'b1;
					end
					if (scan_last) begin
						state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					if (can_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// scan payload registers
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			cmd_q <= req;
		end
		if (state_q == S_SCAN) begin
			idx_s1 <= cnt_q[IDX_W-1:0];
		end
		if ((state_q == S_SCAN) && hit_take) begin
			hit_idx_q  <= idx_s1;
			hit_rank_q <= rd_rank;
		end
		if ((state_q == S_SCAN) && vic_take) begin
			vic_idx_q  <= idx_s1;
			vic_rank_q <= rd_rank;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (can_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (can_fire) begin
			rsp_q <= rsp_n;
		end
	end

endmodule

>>> test/block_buffer_cache_lru_test.sv
// Self-checking testbench for block_buffer_cache_lru, the LRU buffer slot manager.
// Uses bbcl_pkg for payload structs and codes; predicts every result from its own slot table.
// Random gaps on both channels, long result stalls and drain pauses exercise the handshake.
module block_buffer_cache_lru_test;
	import bbcl_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int ITEM_TARGET = 1700;
	localparam int POOL_SIZE   = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	// Slot table shadow used to predict results
	logic [DEV_W-1:0]  slot_dev[SLOTS];
	logic [BLK_W-1:0]  slot_blk[SLOTS];
	logic [HOLD_W-1:0] slot_holders[SLOTS];
	bit                slot_valid[SLOTS];
	bit                slot_dirty[SLOTS];
	int                slot_rank[SLOTS];

	// Tags that gets draw from so that hits are common
	logic [DEV_W-1:0] pool_dev[POOL_SIZE];
	logic [BLK_W-1:0] pool_blk[POOL_SIZE];

	req_t request_backlog[$];
	rsp_t pending_replies[$];
	int   issued = 0;
	int   fault_count = 0;
	int   cycle_count = 0;

	// Sender and receiver pacing
	int send_wait, send_calm;
	int rcv_wait, rcv_calm, long_stall, replies_seen, stalls_done;

	block_buffer_cache_lru DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Apply one request to the slot table and return the result it must produce
	function automatic rsp_t cache_step(req_t r);
		rsp_t o;
		bit found;
		int pick;
		int old_rank;
		o = '0;
		found = 1'b0;
		pick = 0;
		if (r.action == ACT_GET) begin
			// most recent slot holding the tag
			for (int i = 0; i < SLOTS; i++) begin
				if (slot_dev[i] == r.device && slot_blk[i] == r.block_number &&
				    (!found || slot_rank[i] < slot_rank[pick])) begin
					found = 1'b1;
					pick = i;
				end
			end
			if (found) begin
				if (slot_holders[pick] != HOLD_MAX)
					slot_holders[pick] = slot_holders[pick] + 1'b1;
				o.slot_out = IDX_W'(pick);
				o.hit = 1'b1;
				o.disk_request = slot_valid[pick] ? DREQ_NONE : DREQ_READ;
			end else begin
				// least recent unheld clean slot gets recycled
				for (int i = 0; i < SLOTS; i++) begin
					if (slot_holders[i] == 0 && !slot_dirty[i] &&
					    (!found || slot_rank[i] > slot_rank[pick])) begin
						found = 1'b1;
						pick = i;
					end
				end
				if (found) begin
					slot_dev[pick] = r.device;
					slot_blk[pick] = r.block_number;
					slot_valid[pick] = 1'b0;
					slot_dirty[pick] = 1'b0;
					slot_holders[pick] = HOLD_W'(1);
					o.slot_out = IDX_W'(pick);
					o.disk_request = DREQ_READ;
				end else begin
					o.status = STAT_NO_BUF;
				end
			end
		end else begin
			o.slot_out = r.slot;
			if (r.slot >= SLOTS) begin
				o.status = STAT_NOT_HELD;
			end else if (r.action == ACT_DONE) begin
				slot_valid[r.slot] = 1'b1;
				slot_dirty[r.slot] = 1'b0;
			end else if (slot_holders[r.slot] == 0) begin
				o.status = STAT_NOT_HELD;
			end else if (r.action == ACT_WRITE) begin
				slot_dirty[r.slot] = 1'b1;
				o.disk_request = DREQ_WRITE;
			end else begin
				slot_holders[r.slot] = slot_holders[r.slot] - 1'b1;
				// last holder gone: slot becomes most recent
				if (slot_holders[r.slot] == 0) begin
					old_rank = slot_rank[r.slot];
					for (int i = 0; i < SLOTS; i++)
						if (slot_rank[i] < old_rank)
							slot_rank[i]++;
					slot_rank[r.slot] = 0;
				end
			end
		end
		return o;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fault_count++;
		end
	endfunction

	task automatic push_req(action_t act, logic [7:0] dev, logic [31:0] blk, logic [4:0] s);
		req_t r;
		r.action = act;
		r.device = dev;
		r.block_number = blk;
		r.slot = s;
		request_backlog.push_back(r);
		issued++;
	endtask

	// Hold off until every queued request has been answered
	task automatic wait_idle();
		do @(negedge clk);
		while (request_backlog.size() != 0 || req_valid || pending_replies.size() != 0);
	endtask

	// Drop every holder in the table, finishing some dirty slots first
	task automatic queue_release_all();
		for (int i = 0; i < SLOTS; i++) begin
			if (slot_dirty[i] && $urandom_range(0, 1) == 1)
				push_req(ACT_DONE, DEV_W'($urandom), $urandom, 5'(i));
			for (int k = 0; k < slot_holders[i]; k++)
				push_req(ACT_RELEASE, DEV_W'($urandom), $urandom, 5'(i));
		end
	endtask

	// Driver: present queued requests, predict each one on its transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
			send_wait <= 0;
			send_calm <= 0;
		end else begin
			if (req_valid && req_ready)
				pending_replies.push_back(cache_step(req));
			if (!req_valid || req_ready) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1;
					req_valid <= 1'b0;
				end else if (request_backlog.size() != 0) begin
					req <= request_backlog.pop_front();
					req_valid <= 1'b1;
					if (send_calm != 0) begin
						send_calm <= send_calm - 1;
						send_wait <= 0;
					end else begin
						send_wait <= $urandom_range(0, 14);
						if ($urandom_range(0, 24) == 0)
							send_calm <= $urandom_range(10, 40);
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transfer and pace rsp_ready
	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		int w;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rcv_wait <= 0;
			rcv_calm <= 0;
			long_stall <= 0;
			replies_seen <= 0;
			stalls_done <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				replies_seen <= replies_seen + 1;
				if (pending_replies.size() == 0) begin
					$error("result with nothing outstanding: %h", rsp);
					fault_count++;
				end else begin
					want = pending_replies.pop_front();
					check_field("slot_out", want.slot_out, rsp.slot_out);
					check_field("hit", want.hit, rsp.hit);
					check_field("disk_request", want.disk_request, rsp.disk_request);
					check_field("status", want.status, rsp.status);
				end
			end
			if (long_stall != 0) begin
				long_stall <= long_stall - 1;
				rsp_ready <= 1'b0;
			end else if (rsp_valid && rsp_ready) begin
				if (stalls_done < 2 && replies_seen >= 499 + 600 * stalls_done &&
				    request_backlog.size() >= 4) begin
					// long hold-off so the block backs up onto its request side
					long_stall <= 300;
					stalls_done <= stalls_done + 1;
					rsp_ready <= 1'b0;
				end else begin
					if (rcv_calm != 0) begin
						rcv_calm <= rcv_calm - 1;
						w = 0;
					end else begin
						w = $urandom_range(0, 14);
						if ($urandom_range(0, 24) == 0)
							rcv_calm <= $urandom_range(10, 40);
					end
					rsp_ready <= (w == 0);
					rcv_wait <= (w == 0) ? 0 : w - 1;
				end
			end else if (rcv_wait != 0) begin
				rcv_wait <= rcv_wait - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Stimulus
	initial begin
		int held[$];
		int n, get_pct, roll, p;
		action_t act;
		logic [4:0] s;

		for (int i = 0; i < SLOTS; i++) begin
			slot_dev[i] = '0;
			slot_blk[i] = '0;
			slot_holders[i] = '0;
			slot_valid[i] = 1'b0;
			slot_dirty[i] = 1'b0;
			slot_rank[i] = SLOTS - 1 - i;
		end
		pool_dev[0] = 8'h00;
		pool_blk[0] = 32'h0000_0000;
		pool_dev[1] = 8'hFF;
		pool_blk[1] = 32'hFFFF_FFFF;
		for (int i = 2; i < POOL_SIZE; i++) begin
			pool_dev[i] = DEV_W'($urandom);
			pool_blk[i] = $urandom;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero tags hit after reset, extremes, unheld slots, release to zero
		push_req(ACT_GET, 8'h00, 32'h0000_0000, 5'd0);
		push_req(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd31);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd5);
		push_req(ACT_WRITE, 8'h00, 32'h0, 5'd5);
		push_req(ACT_DONE, 8'hFF, 32'hFFFF_FFFF, 5'd5);
		push_req(ACT_WRITE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
		push_req(ACT_DONE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd0);
		push_req(ACT_RELEASE, 8'h00, 32'h0, 5'd31);
		push_req(ACT_WRITE, 8'h00, 32'h0, 5'd31);
		push_req(ACT_GET, 8'h80, 32'h8000_0000, 5'd0);
		push_req(ACT_DONE, 8'h00, 32'h0, 5'd31);
		push_req(ACT_GET, 8'h00, 32'h0000_0000, 5'd0);
		push_req(ACT_GET, 8'h01, 32'h0000_0001, 5'd16);
		push_req(ACT_WRITE, 8'h00, 32'h0, 5'd1);
		wait_idle();

		// Random chunks, each followed by a drain pause
		while (issued < ITEM_TARGET - 520) begin
			if ($urandom_range(0, 9) == 0) begin
				// exhaust the table so gets run out of clean buffers
				for (int k = 0; k < SLOTS + 4; k++)
					push_req(ACT_GET, DEV_W'($urandom), $urandom, 5'($urandom));
				wait_idle();
				queue_release_all();
			end else begin
				held.delete();
				for (int i = 0; i < SLOTS; i++)
					if (slot_holders[i] != 0)
						held.push_back(i);
				n = $urandom_range(10, 60);
				get_pct = 25 * $urandom_range(1, 3);
				for (int k = 0; k < n; k++) begin
					roll = $urandom_range(0, 99);
					if (held.size() != 0 && $urandom_range(0, 4) != 0)
						s = 5'(held[$urandom_range(0, held.size() - 1)]);
					else
						s = 5'($urandom_range(0, SLOTS - 1));
					if (roll < get_pct) begin
						if ($urandom_range(0, 2) != 0) begin
							p = $urandom_range(0, POOL_SIZE - 1);
							push_req(ACT_GET, pool_dev[p], pool_blk[p], s);
						end else begin
							push_req(ACT_GET, DEV_W'($urandom), $urandom, s);
						end
					end else begin
						roll = $urandom_range(0, 9);
						act = (roll < 5) ? ACT_RELEASE : (roll < 8) ? ACT_WRITE : ACT_DONE;
						push_req(act, DEV_W'($urandom), $urandom, s);
					end
				end
			end
			wait_idle();
		end

		// Holder count saturation on one block, then back down to zero
		queue_release_all();
		wait_idle();
		for (int k = 0; k < 258; k++)
			push_req(ACT_GET, 8'h5A, 32'h0000_ABCD, 5'($urandom));
		wait_idle();
		queue_release_all();
		wait_idle();

		repeat (2 * SLOTS + 4) @(posedge clk);
		if (pending_replies.size() != 0) begin
			$error("%0d results never arrived", pending_replies.size());
			fault_count++;
		end
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
